// ===== rtl/tdf_pkg.sv =====
// Package for the trial division factorizer: widths, reset constants and the
// command and status structs between controller and datapath. No dependencies.
`default_nettype none

package tdf_pkg;

  localparam int unsigned VALUE_WIDTH   = 14;
  localparam int unsigned LIMIT_RESET   = 10000;
  localparam int unsigned FIRST_DIVISOR = 2;

  typedef struct packed {
    logic load_in;
    logic emit_err;
    logic emit_rem;
    logic emit_div;
    logic div_start;
    logic inc_div;
  } tdf_cmd_t;

  typedef struct packed {
    logic bad_in;
    logic sq_gt_rem;
    logic div_done;
    logic rem_zero;
    logic quot_one;
    logic out_free;
  } tdf_status_t;

endpackage

`default_nettype wire

// ===== rtl/tdf_if.sv =====
// Channel interfaces of the trial division factorizer: input, result and
// configuration write. Depends on tdf_pkg for the default width.
`default_nettype none

interface tdf_in_if #(
  parameter int unsigned VALUE_WIDTH = tdf_pkg::VALUE_WIDTH
);
  logic                   valid;
  logic                   ready;
  logic [VALUE_WIDTH-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface tdf_out_if #(
  parameter int unsigned VALUE_WIDTH = tdf_pkg::VALUE_WIDTH
);
  logic                   valid;
  logic                   ready;
  logic [VALUE_WIDTH-1:0] factor;
  logic                   last;
  logic                   error;

  modport source (output valid, output factor, output last, output error, input ready);
  modport sink   (input valid, input factor, input last, input error, output ready);
endinterface

interface tdf_cfg_if #(
  parameter int unsigned VALUE_WIDTH = tdf_pkg::VALUE_WIDTH
);
  logic                   valid;
  logic                   ready;
  logic [VALUE_WIDTH-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/tdf_divider.sv =====
// Restoring divider that produces one quotient bit per cycle.
// Depends on tdf_pkg for the default width; quotient and remainder hold after done until the next start.
`default_nettype none

module tdf_divider #(
  parameter int unsigned VALUE_WIDTH = tdf_pkg::VALUE_WIDTH
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   start_i,
  input  wire logic [VALUE_WIDTH-1:0] dividend_i,
  input  wire logic [VALUE_WIDTH-1:0] divisor_i,
  output logic                        done_o,
  output logic [VALUE_WIDTH-1:0]      quotient_o,
  output logic [VALUE_WIDTH-1:0]      remainder_o
);

  localparam int unsigned CntW = $clog2(VALUE_WIDTH + 1);

  logic [VALUE_WIDTH-1:0] acc_q, acc_d;
  logic [VALUE_WIDTH-1:0] quo_q, quo_d;
  logic [VALUE_WIDTH-1:0] den_q;
  logic [CntW-1:0]        cnt_q;
  logic                   busy_q;
  logic                   done_q;
  logic [VALUE_WIDTH:0]   shifted;
  logic [VALUE_WIDTH:0]   diff;

  always_comb begin
    shifted = {acc_q, quo_q[VALUE_WIDTH-1]};
    diff    = shifted - {1'b0, den_q};
    if (!diff[VALUE_WIDTH]) begin
      acc_d = diff[VALUE_WIDTH-1:0];
      quo_d = {quo_q[VALUE_WIDTH-2:0], 1'b1};
    end else begin
      acc_d = shifted[VALUE_WIDTH-1:0];
      quo_d = {quo_q[VALUE_WIDTH-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CntW'(1);
        if (cnt_q == CntW'(VALUE_WIDTH - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= '0;
      quo_q <= dividend_i;
      den_q <= divisor_i;
    end else if (busy_q) begin
      acc_q <= acc_d;
      quo_q <= quo_d;
    end
  end

  assign done_o      = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = acc_q;

endmodule

`default_nettype wire

// ===== rtl/tdf_datapath.sv =====
// Datapath: limit register, cofactor, trial divisor and its square, the
// divider and the result register. Depends on tdf_pkg, tdf_if, tdf_divider.
`default_nettype none

module tdf_datapath #(
  parameter int unsigned VALUE_WIDTH = tdf_pkg::VALUE_WIDTH
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire tdf_pkg::tdf_cmd_t      cmd_i,
  output tdf_pkg::tdf_status_t        status_o,
  input  wire logic [VALUE_WIDTH-1:0] value_i,
  tdf_cfg_if.sink                     cfg_i,
  tdf_out_if.source                   out_o
);

  localparam int unsigned SqW = 2 * VALUE_WIDTH;
  localparam logic [VALUE_WIDTH-1:0] LimitReset = VALUE_WIDTH'(tdf_pkg::LIMIT_RESET);
  localparam logic [VALUE_WIDTH-1:0] FirstDiv   = VALUE_WIDTH'(tdf_pkg::FIRST_DIVISOR);
  localparam logic [SqW-1:0]         FirstSq    =
    SqW'(tdf_pkg::FIRST_DIVISOR * tdf_pkg::FIRST_DIVISOR);

  logic [VALUE_WIDTH-1:0] limit_q;
  logic [VALUE_WIDTH-1:0] rem_q;
  logic [VALUE_WIDTH-1:0] div_q;
  logic [SqW-1:0]         sq_q;
  logic                   out_valid_q;
  logic [VALUE_WIDTH-1:0] factor_q;
  logic                   last_q;
  logic                   error_q;
  logic                   dv_done;
  logic [VALUE_WIDTH-1:0] dv_quot;
  logic [VALUE_WIDTH-1:0] dv_rem;
  logic                   emit;

  tdf_divider #(.VALUE_WIDTH(VALUE_WIDTH)) u_divider (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (cmd_i.div_start),
    .dividend_i  (rem_q),
    .divisor_i   (div_q),
    .done_o      (dv_done),
    .quotient_o  (dv_quot),
    .remainder_o (dv_rem)
  );

  assign cfg_i.ready = 1'b1;
  assign emit = cmd_i.emit_err | cmd_i.emit_rem | cmd_i.emit_div;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q     <= LimitReset;
      rem_q       <= '0;
      div_q       <= FirstDiv;
      sq_q        <= FirstSq;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_i.valid) begin
        limit_q <= cfg_i.data;
      end
      if (cmd_i.load_in) begin
        rem_q <= value_i;
        div_q <= FirstDiv;
        sq_q  <= FirstSq;
      end else if (cmd_i.inc_div) begin
        div_q <= div_q + VALUE_WIDTH'(1);
        sq_q  <= sq_q + {{(SqW - VALUE_WIDTH - 1){1'b0}}, div_q, 1'b1};
      end else if (cmd_i.emit_div) begin
        rem_q <= dv_quot;
      end else if (cmd_i.emit_err | cmd_i.emit_rem) begin
        rem_q <= cmd_i.emit_err ? '0 : VALUE_WIDTH'(1);
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_err) begin
      factor_q <= '0;
      last_q   <= 1'b1;
      error_q  <= 1'b1;
    end else if (cmd_i.emit_rem) begin
      factor_q <= rem_q;
      last_q   <= 1'b1;
      error_q  <= 1'b0;
    end else if (cmd_i.emit_div) begin
      factor_q <= div_q;
      last_q   <= (dv_quot == VALUE_WIDTH'(1));
      error_q  <= 1'b0;
    end
  end

  always_comb begin
    status_o.bad_in    = (rem_q <= VALUE_WIDTH'(1)) || (rem_q > limit_q);
    status_o.sq_gt_rem = sq_q > {{(SqW - VALUE_WIDTH){1'b0}}, rem_q};
    status_o.div_done  = dv_done;
    status_o.rem_zero  = (dv_rem == '0);
    status_o.quot_one  = (dv_quot == VALUE_WIDTH'(1));
    status_o.out_free  = !out_valid_q || out_o.ready;
  end

  assign out_o.valid  = out_valid_q;
  assign out_o.factor = factor_q;
  assign out_o.last   = last_q;
  assign out_o.error  = error_q;

endmodule

`default_nettype wire

// ===== rtl/tdf_ctrl.sv =====
// Controller state machine that sequences range check, square test, division
// and result transfers. Depends on tdf_pkg.
`default_nettype none

module tdf_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire tdf_pkg::tdf_status_t status_i,
  output tdf_pkg::tdf_cmd_t         cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_TEST,
    S_DIV,
    S_FOUND
  } state_e;

  state_e state_q, state_d;
  logic   in_ready_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i && in_ready_q) begin
          cmd_o.load_in = 1'b1;
          state_d       = S_START;
        end
      end
      S_START: begin
        if (!status_i.bad_in) begin
          state_d = S_TEST;
        end else if (status_i.out_free) begin
          cmd_o.emit_err = 1'b1;
          state_d        = S_IDLE;
        end
      end
      S_TEST: begin
        if (!status_i.sq_gt_rem) begin
          cmd_o.div_start = 1'b1;
          state_d         = S_DIV;
        end else if (status_i.out_free) begin
          cmd_o.emit_rem = 1'b1;
          state_d        = S_IDLE;
        end
      end
      S_DIV: begin
        if (status_i.div_done) begin
          if (status_i.rem_zero) begin
            state_d = S_FOUND;
          end else begin
            cmd_o.inc_div = 1'b1;
            state_d       = S_TEST;
          end
        end
      end
      S_FOUND: begin
        if (status_i.out_free) begin
          cmd_o.emit_div = 1'b1;
          state_d        = status_i.quot_one ? S_IDLE : S_TEST;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      in_ready_q <= 1'b1;
    end else begin
      state_q    <= state_d;
      in_ready_q <= (state_d == S_IDLE);
    end
  end

  assign in_ready_o = in_ready_q;

  a_emit_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.emit_err || cmd_o.emit_rem || cmd_o.emit_div) |-> status_i.out_free)
    else $error("result loaded while the output register is occupied");

  a_one_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.emit_err, cmd_o.emit_rem, cmd_o.emit_div}))
    else $error("more than one result loaded in a cycle");

  a_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status_i.div_done |-> (state_q == S_DIV))
    else $error("divider finished outside the division state");

  a_start_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_in |=> (state_q == S_START) && !in_ready_o)
    else $error("accepted item did not start its range check");

endmodule

`default_nettype wire

// ===== rtl/trial_division_factorizer_top.sv =====
// Top level of the trial division factorizer: controller plus datapath.
// Depends on tdf_pkg, tdf_if, tdf_ctrl and tdf_datapath.
//
//   channel  direction  fields               transfer when
//   in_i     sink       value                in_i.valid && in_i.ready
//   out_o    source     factor, last, error  out_o.valid && out_o.ready
//   cfg_i    sink       data (upper_limit)   cfg_i.valid && cfg_i.ready
//
// Each trial divisor is tested with the one-bit-per-cycle divider.
// The divisors tried for an item number at most about sqrt(value).
// A new item is taken once the previous one has loaded its last result.
// A full output register stalls the controller only when it has a result to load.
// Reset is asynchronous and active low; the limit returns to 10000.
`default_nettype none

module trial_division_factorizer_top #(
  parameter int unsigned VALUE_WIDTH = tdf_pkg::VALUE_WIDTH
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  tdf_in_if.sink    in_i,
  tdf_out_if.source out_o,
  tdf_cfg_if.sink   cfg_i
);

  tdf_pkg::tdf_cmd_t    cmd;
  tdf_pkg::tdf_status_t status;

  tdf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  tdf_datapath #(.VALUE_WIDTH(VALUE_WIDTH)) u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .status_o (status),
    .value_i  (in_i.value),
    .cfg_i    (cfg_i),
    .out_o    (out_o)
  );

endmodule

`default_nettype wire
